### hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes of the sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    localparam logic       CMD_ENQ    = 1'b0;
    localparam logic       CMD_DEQ    = 1'b1;

    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic        cmd;
        logic [15:0] handle;
        logic [7:0]  prio;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_handle;
        logic [7:0]  out_prio;
        logic [4:0]  fill;
    } t_out_word;

    typedef struct packed {
        logic [7:0]  prio;
        logic [15:0] handle;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FRONT,
        S_WALK,
        S_DEQ,
        S_RESP
    } t_state;

endpackage

`default_nettype wire

### hw/rtl/spq_ram.sv
// ----------------------------------------------------------------------------
// spq_ram
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ram #(
    parameter int DEPTH = 16
) (
    input  wire                         i_clk,
    input  wire                         i_we,
    input  wire  [$clog2(DEPTH)-1:0]    i_waddr,
    input  spq_pkg::t_entry             i_wdata,
    input  wire                         i_re,
    input  wire  [$clog2(DEPTH)-1:0]    i_raddr,
    output spq_pkg::t_entry             o_rdata
);
    import spq_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hw/rtl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer: ring pointers, entry count and the insertion walk over memory.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ctrl #(
    parameter int DEPTH = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    input  spq_pkg::t_in_word           i_in_word,
    output logic                        o_in_stall,
    output logic                        o_res_valid,
    output spq_pkg::t_out_word          o_res_word,
    input  wire                         i_res_stall,
    output logic                        o_ram_we,
    output logic [$clog2(DEPTH)-1:0]    o_ram_waddr,
    output spq_pkg::t_entry             o_ram_wdata,
    output logic                        o_ram_re,
    output logic [$clog2(DEPTH)-1:0]    o_ram_raddr,
    input  spq_pkg::t_entry             i_ram_rdata
);
    import spq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_state          r_state, n_state;
    logic [AW-1:0]   r_head, n_head;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_cur, n_cur;
    logic [7:0]      r_prio, n_prio;
    logic [15:0]     r_handle, n_handle;
    logic [1:0]      r_status, n_status;
    logic [15:0]     r_rhandle, n_rhandle;
    logic [7:0]      r_rprio, n_rprio;

    logic            front_ins;
    logic            walk_stop;
    logic [CW+4:0]   fill_ext;
    logic [AW-1:0]   last_idx;

    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [AW-1:0] idx);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, idx};
        if (sum >= DEPTH_W) begin
            sum = sum - DEPTH_W;
        end
        return sum[AW-1:0];
    endfunction

    assign front_ins = r_prio < i_ram_rdata.prio;
    assign walk_stop = (r_cur == '0) || (i_ram_rdata.prio < r_prio);
    assign fill_ext  = {5'b0, r_count};
    assign last_idx  = AW'(r_count - CW'(1));
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_word.cmd == CMD_ENQ) begin
                        if (r_count == FULL_CNT || r_count == '0) begin
                            n_state = S_RESP;
                        end else begin
                            n_state = S_FRONT;
                        end
                    end else begin
                        n_state = (r_count == '0) ? S_RESP : S_DEQ;
                    end
                end
            end
            S_FRONT: n_state = front_ins ? S_RESP : S_WALK;
            S_WALK:  n_state = walk_stop ? S_RESP : S_WALK;
            S_DEQ:   n_state = S_RESP;
            S_RESP: begin
                if (!i_res_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_cur       = r_cur;
        n_prio      = r_prio;
        n_handle    = r_handle;
        n_status    = r_status;
        n_rhandle   = r_rhandle;
        n_rprio     = r_rprio;
        o_ram_we    = 1'b0;
        o_ram_waddr = '0;
        o_ram_wdata = '{prio: r_prio, handle: r_handle};
        o_ram_re    = 1'b0;
        o_ram_raddr = r_head;
        o_res_valid = 1'b0;
        o_res_word  = '{status: r_status, out_handle: r_rhandle,
                        out_prio: r_rprio, fill: fill_ext[4:0]};
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_prio    = i_in_word.prio;
                    n_handle  = i_in_word.handle;
                    n_status  = STAT_DONE;
                    n_rhandle = '0;
                    n_rprio   = '0;
                    if (i_in_word.cmd == CMD_ENQ) begin
                        if (r_count == FULL_CNT) begin
                            n_status = STAT_FULL;
                        end else if (r_count == '0) begin
                            o_ram_we    = 1'b1;
                            o_ram_waddr = r_head;
                            o_ram_wdata = '{prio: i_in_word.prio,
                                            handle: i_in_word.handle};
                            n_count     = CW'(1);
                        end else begin
                            o_ram_re = 1'b1;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = STAT_EMPTY;
                        end else begin
                            o_ram_re = 1'b1;
                        end
                    end
                end
            end
            S_FRONT: begin
                if (front_ins) begin
                    n_head      = (r_head == '0) ? LAST_IDX : r_head - AW'(1);
                    o_ram_we    = 1'b1;
                    o_ram_waddr = n_head;
                    n_count     = r_count + CW'(1);
                end else begin
                    n_cur       = last_idx;
                    o_ram_re    = 1'b1;
                    o_ram_raddr = f_phys(r_head, last_idx);
                end
            end
            S_WALK: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = f_phys(r_head, r_cur + AW'(1));
                if (walk_stop) begin
                    n_count = r_count + CW'(1);
                end else begin
                    o_ram_wdata = i_ram_rdata;
                    n_cur       = r_cur - AW'(1);
                    o_ram_re    = 1'b1;
                    o_ram_raddr = f_phys(r_head, r_cur - AW'(1));
                end
            end
            S_DEQ: begin
                n_rhandle = i_ram_rdata.handle;
                n_rprio   = i_ram_rdata.prio;
                n_head    = f_phys(r_head, AW'(1));
                n_count   = r_count - CW'(1);
            end
            S_RESP: begin
                o_res_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur     <= n_cur;
        r_prio    <= n_prio;
        r_handle  <= n_handle;
        r_status  <= n_status;
        r_rhandle <= n_rhandle;
        r_rprio   <= n_rprio;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count above depth");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ram_we && o_ram_re) |-> (o_ram_waddr != o_ram_raddr))
        else $error("read and write hit the same entry");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (CW'(r_cur) < r_count))
        else $error("walk index beyond stored entries");

    a_walk_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |=> $stable(r_head))
        else $error("head moved during insertion walk");

endmodule

`default_nettype wire

### hw/rtl/sorted_priority_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Priority queue of up to DEPTH (handle, priority) entries held in sorted
// order in a ring inside one synchronous memory.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                word
//  in        input      i_in_valid / o_in_stall  cmd, handle, prio
//  out       output     o_out_valid / i_out_stall status, out_handle, out_prio, fill
//
//  Dequeue and front insertion pass through S_DEQ or S_FRONT to S_RESP; full or
//  empty results go straight to S_RESP. Other enqueues walk from the tail one
//  entry per cycle over the memory read port, shifting entries up by one.
//  Reset empties the queue at once; memory contents are not cleared.
//  A result waits in the output register while the next word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_core #(
    parameter int DEPTH = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  spq_pkg::t_in_word    i_in_word,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output spq_pkg::t_out_word   o_out_word,
    input  wire                  i_out_stall
);
    import spq_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic            res_valid;
    t_out_word       res_word;
    logic            res_stall;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    t_entry          ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    t_entry          ram_rdata;

    logic            r_out_valid;
    t_out_word       r_out_word;

    spq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_stall  (o_in_stall),
        .o_res_valid (res_valid),
        .o_res_word  (res_word),
        .i_res_stall (res_stall),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    spq_ram #(.DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign res_stall = r_out_valid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!res_stall) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!res_stall && res_valid) begin
            r_out_word <= res_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

### test/spq_tracker_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spq_tracker_pkg
// Scoreboard for the sorted priority queue. It keeps its own sorted copy of
// the queue, works out the result word for each accepted input word, and
// matches result words against those predictions in order.
// ----------------------------------------------------------------------------

package spq_tracker_pkg;

    import spq_pkg::*;

    class spq_sorted_tracker #(int DEPTH = 16);

        logic [7:0]  ent_prio[DEPTH];
        logic [15:0] ent_handle[DEPTH];
        int unsigned held;
        t_out_word   pending_results[$];

        int unsigned n_checked;
        int unsigned n_mismatch;
        int unsigned n_enq;
        int unsigned n_deq;
        int unsigned n_full;
        int unsigned n_empty;
        int unsigned max_held;

        function new();
            held       = 0;
            n_checked  = 0;
            n_mismatch = 0;
            n_enq      = 0;
            n_deq      = 0;
            n_full     = 0;
            n_empty    = 0;
            max_held   = 0;
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        function void take_word(t_in_word w);
            t_out_word   res;
            int unsigned pos;
            int unsigned i;
            res = '0;
            if (w.cmd == CMD_ENQ) begin
                n_enq++;
                if (held >= DEPTH) begin
                    res.status = STAT_FULL;
                    n_full++;
                end else begin
                    if (held == 0 || w.prio < ent_prio[0]) begin
                        pos = 0;
                    end else begin
                        pos = 1;
                        while (pos < held && w.prio > ent_prio[pos])
                            pos++;
                    end
                    for (i = held; i > pos; i--) begin
                        ent_prio[i]   = ent_prio[i-1];
                        ent_handle[i] = ent_handle[i-1];
                    end
                    ent_prio[pos]   = w.prio;
                    ent_handle[pos] = w.handle;
                    held++;
                    res.status = STAT_DONE;
                end
            end else begin
                n_deq++;
                if (held == 0) begin
                    res.status = STAT_EMPTY;
                    n_empty++;
                end else begin
                    res.out_handle = ent_handle[0];
                    res.out_prio   = ent_prio[0];
                    for (i = 1; i < held; i++) begin
                        ent_prio[i-1]   = ent_prio[i];
                        ent_handle[i-1] = ent_handle[i];
                    end
                    held--;
                    res.status = STAT_DONE;
                end
            end
            if (held > max_held)
                max_held = held;
            res.fill = 5'(held);
            pending_results.push_back(res);
        endfunction

        function void match_result(t_out_word got);
            t_out_word want;
            n_checked++;
            if (pending_results.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("result %0d arrived with nothing outstanding: status=%0d handle=%h prio=%h fill=%0d",
                             n_checked, got.status, got.out_handle, got.out_prio, got.fill);
                return;
            end
            want = pending_results.pop_front();
            if (got.status != want.status || got.out_handle != want.out_handle ||
                got.out_prio != want.out_prio || got.fill != want.fill) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("result %0d mismatch: expected status=%0d handle=%h prio=%h fill=%0d, got status=%0d handle=%h prio=%h fill=%0d",
                             n_checked, want.status, want.out_handle, want.out_prio, want.fill,
                             got.status, got.out_handle, got.out_prio, got.fill);
            end
        endfunction

    endclass

endpackage

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench of sorted_priority_queue_core. A directed run covers empty and
// front cases, equal priorities and the priority extremes; random phases
// then fill, overflow and drain the queue with random gaps on the input and
// random stall on the output, while the scoreboard checks every result word.
// ----------------------------------------------------------------------------

module tb;

    import spq_pkg::*;
    import spq_tracker_pkg::*;

    localparam int DEPTH      = 16;
    localparam int RAND_ITEMS = 1550;

    typedef enum int {PRIO_WIDE, PRIO_NARROW, PRIO_EDGE} t_prio_mode;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    t_in_word  i_in_word;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;
    logic      i_out_stall;

    spq_sorted_tracker #(DEPTH) sb;

    sorted_priority_queue_core #(.DEPTH(DEPTH)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.match_result(o_out_word);
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] pick_prio(t_prio_mode mode, logic [7:0] base);
        case (mode)
            PRIO_NARROW: return base + 8'($urandom_range(0, 3));
            PRIO_EDGE:   return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default:     return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic drive_word(t_in_word w);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        sb.take_word(w);
    endtask

    task automatic idle_in(int n);
        repeat (n) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
    endtask

    task automatic send(logic cmd, logic [15:0] handle, logic [7:0] prio);
        t_in_word w;
        w.cmd    = cmd;
        w.handle = handle;
        w.prio   = prio;
        drive_word(w);
        idle_in(gap_len());
    endtask

    task automatic wait_drained();
        idle_in(1);
        while (sb.pending() != 0)
            @(negedge i_clk);
    endtask

    // output stall: runs of random length, mostly short, some long free stretches
    initial begin
        int r;
        int len;
        logic v;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                v = 1'b0; len = $urandom_range(1, 20);
            end else if (r < 50) begin
                v = 1'b0; len = $urandom_range(50, 200);
            end else if (r < 85) begin
                v = 1'b1; len = $urandom_range(1, 3);
            end else if (r < 97) begin
                v = 1'b1; len = $urandom_range(4, 10);
            end else begin
                v = 1'b1; len = $urandom_range(20, 40);
            end
            repeat (len) begin
                @(negedge i_clk);
                i_out_stall <= v;
            end
        end
    end

    initial begin
        t_in_word   w;
        t_prio_mode mode;
        logic [7:0] base;
        int         enq_pct;
        int         len;
        int         n_rand;
        int         phase;
        int         n_wait;
        int         n_left;
        bit         burst;

        sb         = new();
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_word  = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty, front insert, equal priorities, extremes
        send(CMD_DEQ, 16'hFFFF, 8'hFF);
        send(CMD_ENQ, 16'h0000, 8'h80);
        send(CMD_ENQ, 16'hFFFF, 8'h40);
        send(CMD_ENQ, 16'h1111, 8'h40);
        send(CMD_ENQ, 16'h2222, 8'h90);
        send(CMD_ENQ, 16'h3333, 8'h90);
        send(CMD_ENQ, 16'h4444, 8'h00);
        send(CMD_ENQ, 16'h5555, 8'hFF);
        send(CMD_ENQ, 16'h6666, 8'hFF);
        send(CMD_ENQ, 16'hA5A5, 8'h7F);
        repeat (9) send(CMD_DEQ, 16'h0000, 8'h00);
        send(CMD_DEQ, 16'h0000, 8'h00);
        send(CMD_ENQ, 16'h5A5A, 8'h01);
        send(CMD_DEQ, 16'hFFFF, 8'hFF);

        // random phases: fill, overflow, drain, balanced traffic
        n_rand = 0;
        phase  = 0;
        while (n_rand < RAND_ITEMS) begin
            case ($urandom_range(0, 3))
                0:       enq_pct = 95;
                1:       enq_pct = 80;
                2:       enq_pct = 50;
                default: enq_pct = 15;
            endcase
            mode  = t_prio_mode'($urandom_range(0, 2));
            base  = 8'($urandom_range(0, 255));
            burst = ($urandom_range(0, 4) == 0);
            len   = $urandom_range(20, 80);
            if (phase == 3 || $urandom_range(0, 9) == 0)
                wait_drained();
            for (int k = 0; k < len && n_rand < RAND_ITEMS; k++) begin
                w.cmd    = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
                w.handle = 16'($urandom);
                w.prio   = pick_prio(mode, base);
                drive_word(w);
                n_rand++;
                if (!burst)
                    idle_in(gap_len());
            end
            phase++;
        end

        idle_in(1);
        n_wait = 0;
        while (sb.pending() != 0 && n_wait < 20000) begin
            @(posedge i_clk);
            n_wait++;
        end
        repeat (DEPTH + 8) @(posedge i_clk);
        n_left = sb.pending();

        $display("Ran %0d enqueues (%0d dropped full) and %0d dequeues (%0d on empty),",
                 sb.n_enq, sb.n_full, sb.n_deq, sb.n_empty);
        $display("peak fill %0d; checked %0d results: %0d mismatches, %0d missing",
                 sb.max_held, sb.n_checked, sb.n_mismatch, n_left);
        if (sb.n_mismatch == 0 && n_left == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
